/* hdl/vtae_pkg.sv */
package vtae_pkg;

    localparam int NumSlots = 14;

    localparam logic [7:0] ChEsc   = 8'h1b;
    localparam logic [7:0] ChGs    = 8'h1d;
    localparam logic [7:0] ChR     = 8'h52;
    localparam logic [7:0] ChOne   = 8'h31;
    localparam logic [7:0] HiBase  = 8'h20;
    localparam logic [7:0] LoYBase = 8'h60;
    localparam logic [7:0] LoXBase = 8'h40;

    localparam logic KindTen    = 1'b0;
    localparam logic ActionMove = 1'b0;

    typedef struct packed {
        logic [NumSlots-1:0]      mask;
        logic [NumSlots-1:0][7:0] bytes;
    } t_cmd;

    typedef struct packed {
        logic [7:0] yh;
        logic [7:0] ex;
        logic [7:0] yl;
        logic [7:0] xh;
        logic [7:0] xl;
    } t_addr;

    function automatic t_addr addr10(input logic [11:0] x, input logic [11:0] y);
        t_addr a;
        a.yh = HiBase  + {3'b000, y[9:5]};
        a.ex = 8'h00;
        a.yl = LoYBase + {3'b000, y[4:0]};
        a.xh = HiBase  + {3'b000, x[9:5]};
        a.xl = LoXBase + {3'b000, x[4:0]};
        return a;
    endfunction

    function automatic t_addr addr12(input logic [11:0] x, input logic [11:0] y);
        t_addr a;
        a.yh = HiBase  + {3'b000, y[11:7]};
        a.ex = LoYBase + {4'b0000, y[1:0], x[1:0]};
        a.yl = LoYBase + {3'b000, y[6:2]};
        a.xh = HiBase  + {3'b000, x[11:7]};
        a.xl = LoXBase + {3'b000, x[6:2]};
        return a;
    endfunction

endpackage

/* hdl/vtae_front.sv */
module vtae_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_wr_en,
    input  logic           i_cfg_wr_data,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic           i_action,
    input  logic [11:0]    i_x,
    input  logic [11:0]    i_y,
    input  logic           i_q_full,
    output logic           o_push,
    output vtae_pkg::t_cmd o_cmd
);
    import vtae_pkg::*;

    logic        r_kind;
    logic [7:0]  r_yh, r_yl, r_xh;
    logic [11:0] r_pen_x, r_pen_y;
    logic [7:0]  n_yh, n_yl, n_xh;

    logic        accept;
    logic        move;
    logic        straight;
    logic [7:0]  hist_yh, hist_yl, hist_xh;
    t_addr       a10, a_p, a_n;
    t_cmd        cmd;

    assign o_ready  = !i_q_full;
    assign accept   = i_valid && o_ready;
    assign move     = (i_action == ActionMove);
    assign straight = (i_x == r_pen_x) || (i_y == r_pen_y);
    assign hist_yh  = move ? 8'h00 : r_yh;
    assign hist_yl  = move ? 8'h00 : r_yl;
    assign hist_xh  = move ? 8'h00 : r_xh;
    assign a10      = addr10(i_x, i_y);
    assign a_p      = addr12(r_pen_x, r_pen_y);
    assign a_n      = addr12(i_x, i_y);

    always_comb begin
        cmd  = '0;
        n_yh = r_yh;
        n_yl = r_yl;
        n_xh = r_xh;
        if (r_kind == KindTen) begin
            cmd.bytes[0] = ChGs;
            cmd.bytes[1] = a10.yh;
            cmd.bytes[2] = a10.yl;
            cmd.bytes[3] = a10.xh;
            cmd.bytes[4] = a10.xl;
            cmd.mask[0]  = move;
            cmd.mask[1]  = (a10.yh != hist_yh);
            cmd.mask[2]  = (a10.xh != hist_xh) || (a10.yl != hist_yl);
            cmd.mask[3]  = (a10.xh != hist_xh);
            cmd.mask[4]  = 1'b1;
            n_yh = a10.yh;
            n_yl = a10.yl;
            n_xh = a10.xh;
        end else if (move) begin
            n_yh = 8'h00;
            n_yl = 8'h00;
            n_xh = 8'h00;
        end else if (straight) begin
            cmd.bytes[0]  = ChEsc;
            cmd.bytes[1]  = ChR;
            cmd.bytes[2]  = ChR;
            cmd.bytes[3]  = a_p.yh;
            cmd.bytes[4]  = a_p.ex;
            cmd.bytes[5]  = a_p.yl;
            cmd.bytes[6]  = a_p.xh;
            cmd.bytes[7]  = a_p.xl;
            cmd.bytes[8]  = a_n.yh;
            cmd.bytes[9]  = a_n.ex;
            cmd.bytes[10] = a_n.yl;
            cmd.bytes[11] = a_n.xh;
            cmd.bytes[12] = a_n.xl;
            cmd.bytes[13] = ChOne;
            cmd.mask      = '1;
            cmd.mask[3]   = (a_p.yh != r_yh);
            cmd.mask[6]   = (a_p.xh != r_xh);
            cmd.mask[8]   = (a_n.yh != a_p.yh);
            cmd.mask[11]  = (a_n.xh != a_p.xh);
            n_yh = a_n.yh;
            n_yl = a_n.yl;
            n_xh = a_n.xh;
        end
    end

    assign o_cmd  = cmd;
    assign o_push = accept && (|cmd.mask);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind  <= KindTen;
            r_yh    <= 8'h00;
            r_yl    <= 8'h00;
            r_xh    <= 8'h00;
            r_pen_x <= 12'h000;
            r_pen_y <= 12'h000;
        end else begin
            if (i_cfg_wr_en) begin
                r_kind <= i_cfg_wr_data;
            end
            if (accept) begin
                r_yh    <= n_yh;
                r_yl    <= n_yl;
                r_xh    <= n_xh;
                r_pen_x <= i_x;
                r_pen_y <= i_y;
            end
        end
    end

endmodule

/* hdl/vtae_queue.sv */
module vtae_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  vtae_pkg::t_cmd i_data,
    output logic           o_full,
    output logic           o_valid,
    input  logic           i_pop,
    output vtae_pkg::t_cmd o_data
);
    import vtae_pkg::*;

    t_cmd       r_entry [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_entry[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

/* hdl/vtae_back.sv */
module vtae_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  vtae_pkg::t_cmd i_q_data,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [7:0]     o_byte,
    output logic           o_last
);
    import vtae_pkg::*;

    logic [NumSlots-1:0]      r_mask;
    logic [NumSlots-1:0][7:0] r_bytes;
    logic                     r_valid;
    logic [7:0]               r_byte;
    logic                     r_last;

    logic                     out_free;
    logic                     emit;
    logic [NumSlots-1:0]      low_bit;
    logic [NumSlots-1:0]      rest;
    logic [7:0]               sel_byte;

    assign out_free = !r_valid || i_ready;
    assign emit     = out_free && (|r_mask);
    assign low_bit  = r_mask & (~r_mask + 1'b1);
    assign rest     = r_mask & ~low_bit;
    assign o_pop    = i_q_valid && ((r_mask == '0) || (emit && (rest == '0)));

    always_comb begin
        sel_byte = 8'h00;
        for (int i = 0; i < NumSlots; i++) begin
            sel_byte = sel_byte | (r_bytes[i] & {8{low_bit[i]}});
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_bytes <= i_q_data.bytes;
        end
        if (emit) begin
            r_byte <= sel_byte;
            r_last <= (rest == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_mask <= i_q_data.mask;
            end else if (emit) begin
                r_mask <= rest;
            end
            if (out_free) begin
                r_valid <= emit;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_last  = r_last;

endmodule

/* hdl/vector_terminal_address_encoder.sv */
// The first byte of a command passes the queue entry, the back end's mask and byte registers
// and the output byte register. Bytes leave at one per cycle while m_axis_tready is high;
// a command emits zero to fourteen bytes, and the single byte output register sets this
// rate. Empty commands are not queued; a two-entry queue decouples the sides.
// Synchronous active-low reset clears the history bytes, the pen, the terminal kind and the
// queue; no clearing pass is needed.
module vector_terminal_address_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // x_coord [11:0], y_coord [23:12]
    input  logic        s_axis_tuser,   // action [0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // out_byte [7:0]
    output logic        m_axis_tlast
);
    import vtae_pkg::*;

    logic q_full;
    logic push;
    logic q_valid;
    logic pop;
    t_cmd push_cmd;
    t_cmd q_cmd;

    vtae_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_action      (s_axis_tuser),
        .i_x           (s_axis_tdata[11:0]),
        .i_y           (s_axis_tdata[23:12]),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    vtae_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_data  (q_cmd)
    );

    vtae_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_cmd),
        .o_pop     (pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_byte    (m_axis_tdata),
        .o_last    (m_axis_tlast)
    );

endmodule

/* bench/tb_vector_terminal_address_encoder.sv */
`timescale 1ns / 100ps

module tb_vector_terminal_address_encoder;
    import vtae_pkg::*;

    localparam logic KindTwelve = 1'b1;
    localparam logic ActionDraw = 1'b1;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_term_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic        i_cfg_wr_data = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;     // x_coord [11:0], y_coord [23:12]
    logic        s_axis_tuser = 1'b0;   // action [0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;          // out_byte [7:0]
    logic        m_axis_tlast;

    // Predictor state.
    logic        term_kind = KindTen;
    logic [7:0]  hist_y_high = '0;
    logic [7:0]  hist_y_low = '0;
    logic [7:0]  hist_x_high = '0;
    logic [11:0] pen_x = '0;
    logic [11:0] pen_y = '0;

    logic [7:0]  cmd_seq[$];
    t_term_byte  term_bytes_due[$];

    int          mismatches = 0;
    int          hold_cycles = 0;
    bit          idling_on = 1'b1;

    vector_terminal_address_encoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("vector_terminal_address_encoder: mismatch");
        $finish;
    end

    function automatic int idle_gap();
        int r;
        r = $urandom_range(99);
        if (!idling_on || r < 65) begin
            return 0;
        end else if (r < 93) begin
            return $urandom_range(3, 1);
        end
        return $urandom_range(25, 8);
    endfunction

    function automatic void point_ten(input logic [11:0] x, input logic [11:0] y);
        logic [7:0] yh;
        logic [7:0] yl;
        logic [7:0] xh;
        logic [7:0] xl;
        bit         yh_new;
        bit         xh_new;
        bit         yl_new;
        yh = HiBase + {3'b000, y[9:5]};
        yl = LoYBase + {3'b000, y[4:0]};
        xh = HiBase + {3'b000, x[9:5]};
        xl = LoXBase + {3'b000, x[4:0]};
        yh_new = (hist_y_high != yh);
        xh_new = (hist_x_high != xh);
        yl_new = (hist_y_low != yl);
        if (yh_new) begin
            cmd_seq.push_back(yh);
        end
        if (xh_new || yl_new) begin
            cmd_seq.push_back(yl);
        end
        if (xh_new) begin
            cmd_seq.push_back(xh);
        end
        cmd_seq.push_back(xl);
        hist_y_high = yh;
        hist_y_low = yl;
        hist_x_high = xh;
    endfunction

    function automatic void point_twelve(input logic [11:0] x, input logic [11:0] y);
        logic [7:0] yh;
        logic [7:0] yl;
        logic [7:0] xh;
        yh = HiBase + {3'b000, y[11:7]};
        yl = LoYBase + {3'b000, y[6:2]};
        xh = HiBase + {3'b000, x[11:7]};
        if (hist_y_high != yh) begin
            cmd_seq.push_back(yh);
        end
        cmd_seq.push_back(LoYBase + {4'b0000, y[1:0], x[1:0]});
        cmd_seq.push_back(yl);
        if (hist_x_high != xh) begin
            cmd_seq.push_back(xh);
        end
        cmd_seq.push_back(LoXBase + {3'b000, x[6:2]});
        hist_y_high = yh;
        hist_y_low = yl;
        hist_x_high = xh;
    endfunction

    function automatic void encode_command(input logic action, input logic [11:0] x,
                                           input logic [11:0] y);
        t_term_byte tb_item;
        cmd_seq.delete();
        if (action == ActionMove) begin
            hist_y_high = '0;
            hist_y_low = '0;
            hist_x_high = '0;
            if (term_kind == KindTen) begin
                cmd_seq.push_back(ChGs);
                point_ten(x, y);
            end
        end else if (term_kind == KindTen) begin
            point_ten(x, y);
        end else if (x == pen_x || y == pen_y) begin
            cmd_seq.push_back(ChEsc);
            cmd_seq.push_back(ChR);
            cmd_seq.push_back(ChR);
            point_twelve(pen_x, pen_y);
            point_twelve(x, y);
            cmd_seq.push_back(ChOne);
        end
        pen_x = x;
        pen_y = y;
        for (int i = 0; i < cmd_seq.size(); i++) begin
            tb_item.data = cmd_seq[i];
            tb_item.last = (i == cmd_seq.size() - 1);
            term_bytes_due.push_back(tb_item);
        end
    endfunction

    task automatic send_cmd(input logic action, input logic [11:0] x, input logic [11:0] y);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {y, x};
        s_axis_tuser  <= action;
        do @(posedge i_clk); while (!s_axis_tready);
        encode_command(action, x, y);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (term_bytes_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_kind(input logic kind);
        wait_idle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= kind;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        term_kind = kind;
    endtask

    function automatic logic [11:0] near_coord(input logic [11:0] v);
        int r;
        r = $urandom_range(99);
        if (r < 35) begin
            return 12'($urandom_range(4095));
        end else if (r < 60) begin
            return v ^ 12'($urandom_range(31));
        end else if (r < 75) begin
            return v ^ (12'd1 << $urandom_range(11));
        end else if (r < 85) begin
            return ($urandom_range(1) == 0) ? 12'd0 : 12'd4095;
        end
        return v;
    endfunction

    task automatic send_random_cmd();
        logic        action;
        logic [11:0] x;
        logic [11:0] y;
        action = ($urandom_range(9) < 2) ? ActionMove : ActionDraw;
        x = near_coord(pen_x);
        y = near_coord(pen_y);
        if (term_kind == KindTwelve && action == ActionDraw && $urandom_range(99) < 85) begin
            if ($urandom_range(1) == 0) begin
                x = pen_x;
            end else begin
                y = pen_y;
            end
        end
        send_cmd(action, x, y);
    endtask

    task automatic test_ten_bit_encoding();
        set_kind(KindTen);
        send_cmd(ActionMove, 12'd0, 12'd0);
        send_cmd(ActionMove, 12'd4095, 12'd4095);
        send_cmd(ActionDraw, 12'd1023, 12'd1023);
        send_cmd(ActionDraw, 12'd1023, 12'd1023);
        send_cmd(ActionDraw, 12'd1000, 12'd1023);
        send_cmd(ActionDraw, 12'd1000, 12'd1000);
        send_cmd(ActionDraw, 12'd200, 12'd1000);
        send_cmd(ActionDraw, 12'd200, 12'd8);
        send_cmd(ActionDraw, 12'hc00, 12'h800);
    endtask

    task automatic test_twelve_bit_encoding();
        set_kind(KindTwelve);
        send_cmd(ActionMove, 12'd100, 12'd100);
        send_cmd(ActionDraw, 12'd4095, 12'd100);
        send_cmd(ActionDraw, 12'd4095, 12'd4095);
        send_cmd(ActionDraw, 12'd0, 12'd0);
        send_cmd(ActionDraw, 12'd0, 12'd0);
        send_cmd(ActionDraw, 12'd0, 12'd2049);
        send_cmd(ActionMove, 12'd4095, 12'd0);
        send_cmd(ActionDraw, 12'd3, 12'd0);
    endtask

    task automatic test_kind_switch();
        set_kind(KindTen);
        send_cmd(ActionDraw, 12'd511, 12'd300);
        set_kind(KindTwelve);
        send_cmd(ActionDraw, 12'd511, 12'd4000);
        set_kind(KindTen);
        send_cmd(ActionDraw, 12'd17, 12'd4000);
        send_cmd(ActionMove, 12'd17, 12'd4000);
    endtask

    task automatic test_random_commands(input logic kind, input int count);
        set_kind(kind);
        repeat (count) send_random_cmd();
    endtask

    task automatic test_output_backpressure();
        set_kind(KindTwelve);
        idling_on = 1'b0;
        hold_cycles = 300;
        repeat (20) send_random_cmd();
        wait_idle();
        idling_on = 1'b1;
    endtask

    initial begin
        int rx_wait;
        rx_wait = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                if (term_bytes_due.size() == 0) begin
                    $display("%0t: unexpected request: expected none, actual data %h last %b",
                             $time, m_axis_tdata, m_axis_tlast);
                    mismatches++;
                end else begin
                    if (m_axis_tdata != term_bytes_due[0].data) begin
                        $display("%0t: data: expected %h, actual %h",
                                 $time, term_bytes_due[0].data, m_axis_tdata);
                        mismatches++;
                    end
                    if (m_axis_tlast != term_bytes_due[0].last) begin
                        $display("%0t: last: expected %b, actual %b",
                                 $time, term_bytes_due[0].last, m_axis_tlast);
                        mismatches++;
                    end
                    void'(term_bytes_due.pop_front());
                end
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_axis_tready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                rx_wait = idle_gap();
            end
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_ten_bit_encoding();
        test_twelve_bit_encoding();
        test_kind_switch();
        test_random_commands(KindTen, 45);
        test_random_commands(KindTwelve, 45);
        test_output_backpressure();
        test_random_commands(KindTen, 20);
        test_random_commands(KindTwelve, 20);
        wait_idle();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("vector_terminal_address_encoder: match");
        end else begin
            $display("vector_terminal_address_encoder: mismatch");
        end
        $finish;
    end

endmodule
